@@ sv/scdb_pkg.sv @@
// Package for the stylus coordinate delta blender: widths, weight constants,
// register indexes, reset values and the lane control struct.
// No dependencies; the lane, the top level and the testbench import it.
package scdb_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int WEIGHT_BITS = 8;
    localparam int WEIGHT_ONE  = 1 << WEIGHT_BITS;
    localparam int WEIGHT_W    = WEIGHT_BITS + 1;
    localparam int WEIGHT_MIN  = 3;
    localparam int CFG_W       = 16;

    localparam int DELTA_W  = COORD_BITS + 1;
    localparam int SMOOTH_W = COORD_BITS + FRAC_BITS + 1;
    localparam int PROD_W   = SMOOTH_W + WEIGHT_W + 1;
    localparam int ACC_W    = PROD_W + 1;
    localparam int CORR_W   = COORD_BITS + 1;
    localparam int SUM_W    = COORD_BITS + 2;

    localparam logic               ENABLE_RESET    = 1'b1;
    localparam logic [CFG_W-1:0]   MAX_DELTA_RESET = CFG_W'(64);
    localparam logic [WEIGHT_W-1:0] SMOOTH_RESET   = WEIGHT_W'(64);
    localparam logic [WEIGHT_W-1:0] BLEND_RESET    = WEIGHT_W'(128);

    typedef enum logic [1:0] {
        REG_ENABLE,
        REG_MAX_DELTA,
        REG_SMOOTHING_WEIGHT,
        REG_BLEND_WEIGHT
    } reg_index_t;

    // Per-cycle commands from the sequencer to both axis lanes.
    typedef struct packed {
        logic clear;
        logic seed;
        logic smooth_mul;
        logic smooth_upd;
        logic blend_mul;
    } lane_ctrl_t;

endpackage

@@ sv/scdb_if.sv @@
// Handshake channels of the stylus coordinate delta blender: the frame input
// and the result output, each with valid, ready and payload.
// No dependencies.
interface scdb_frame_if;
    logic        valid;
    logic        ready;
    logic        primary_valid;
    logic [15:0] primary_x;
    logic [15:0] primary_y;
    logic        secondary_valid;
    logic [15:0] secondary_x;
    logic [15:0] secondary_y;
    logic [15:0] pressure;

    modport source (output valid, primary_valid, primary_x, primary_y,
                    secondary_valid, secondary_x, secondary_y, pressure,
                    input ready);
    modport sink   (input valid, primary_valid, primary_x, primary_y,
                    secondary_valid, secondary_x, secondary_y, pressure,
                    output ready);
endinterface

interface scdb_result_if;
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [15:0] out_x;
    logic [15:0] out_y;

    modport source (output valid, out_valid, out_x, out_y, input ready);
    modport sink   (input valid, out_valid, out_x, out_y, output ready);
endinterface

@@ sv/scdb_lane.sv @@
// One axis lane: raw delta and limit check, smoothed delta state with its IIR
// update, and the weighted blend with rounding and saturation.
// Depends on scdb_pkg.
module scdb_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scdb_pkg::lane_ctrl_t                ctrl,
    input  logic [scdb_pkg::COORD_BITS-1:0]     base,
    input  logic [scdb_pkg::COORD_BITS-1:0]     other,
    input  logic [scdb_pkg::CFG_W-1:0]          max_delta,
    input  logic [scdb_pkg::WEIGHT_W-1:0]       weight_new,
    input  logic [scdb_pkg::WEIGHT_W-1:0]       weight_old,
    input  logic [scdb_pkg::WEIGHT_W-1:0]       weight_blend,
    output logic                                too_big,
    output logic [scdb_pkg::COORD_BITS-1:0]     coord
);
    import scdb_pkg::*;

    // Divide by 2**sh, rounding half away from zero.
    function automatic logic signed [ACC_W-1:0] round_shr(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             sh
    );
        logic signed [ACC_W:0] ve;
        logic        [ACC_W:0] mag;
        ve  = (ACC_W+1)'(v);
        mag = ve[ACC_W] ? (ACC_W+1)'(-ve) : (ACC_W+1)'(ve);
        mag = (mag + ((ACC_W+1)'(1) << (sh - 1))) >> sh;
        return ve[ACC_W] ? ACC_W'(-$signed(mag)) : ACC_W'($signed(mag));
    endfunction

    logic signed [SMOOTH_W-1:0] s_reg, s_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic signed [DELTA_W-1:0]  delta;
    logic        [DELTA_W-1:0]  delta_mag;
    logic signed [SMOOTH_W-1:0] seed_val;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    smooth_round;
    logic signed [ACC_W-1:0]    corr_round;
    logic signed [CORR_W-1:0]   corr;
    logic signed [SUM_W-1:0]    sum;

    assign delta     = $signed({1'b0, other}) - $signed({1'b0, base});
    assign delta_mag = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
    assign too_big   = delta_mag > DELTA_W'(max_delta);
    assign seed_val  = SMOOTH_W'(delta) <<< FRAC_BITS;

    assign acc_next = ACC_W'(s_reg) * ACC_W'($signed({1'b0, weight_old}))
                    + ACC_W'(seed_val) * ACC_W'($signed({1'b0, weight_new}));
    assign prod_next = PROD_W'(s_reg) * PROD_W'($signed({1'b0, weight_blend}));

    assign smooth_round = round_shr(acc_reg, WEIGHT_BITS);
    assign corr_round   = round_shr(ACC_W'(prod_reg), WEIGHT_BITS + FRAC_BITS);
    assign corr         = corr_round[CORR_W-1:0];
    assign sum          = SUM_W'($signed({1'b0, base})) + SUM_W'(corr);

    always_comb
    begin
        priority if (sum[SUM_W-1])
        begin
            coord = '0;
        end
        else if (sum[COORD_BITS])
        begin
            coord = '1;
        end
        else
        begin
            coord = sum[COORD_BITS-1:0];
        end
    end

    always_comb
    begin
        priority if (ctrl.seed)
        begin
            s_next = seed_val;
        end
        else if (ctrl.clear)
        begin
            s_next = '0;
        end
        else if (ctrl.smooth_upd)
        begin
            s_next = smooth_round[SMOOTH_W-1:0];
        end
        else
        begin
            s_next = s_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
        end
        else
        begin
            s_reg <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.smooth_mul)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.blend_mul)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

@@ sv/stylus_coordinate_delta_blender.sv @@
// Top level of the stylus coordinate delta blender: configuration registers,
// the frame sequencer that merges the two lane decisions, and the result register.
// Depends on scdb_pkg, scdb_if (scdb_frame_if, scdb_result_if) and scdb_lane.
//
//   channel   direction  handshake      payload
//   frame     in         valid/ready    primary_valid/x/y, secondary_valid/x/y, pressure
//   result    out        valid/ready    out_valid, out_x, out_y
//   wr_*      in         wr_en only     wr_index, wr_data
//
// A frame is taken in the idle step and its result register is loaded at the end of four steps:
// limit check, smoothing update, blend multiply, then round, saturate and load.
// A new frame is not taken until the previous one has run the four-step sequence shared by
// both lanes. A new frame is taken in the cycle after the result register is loaded,
// while that result may still wait. A stalled result holds the sequencer in its last
// step. Reset restores the register defaults and clears the smoothing state; no clearing
// pass is needed.
module stylus_coordinate_delta_blender (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  scdb_pkg::reg_index_t          wr_index,
    input  logic [scdb_pkg::CFG_W-1:0]    wr_data,
    scdb_frame_if.sink                    frame,
    scdb_result_if.source                 result
);
    import scdb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SMOOTH,
        ST_BLEND,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic                  enable_reg;
    logic [CFG_W-1:0]      max_delta_reg;
    logic [WEIGHT_W-1:0]   smoothing_weight_reg;
    logic [WEIGHT_W-1:0]   blend_weight_reg;

    logic                  pv_reg;
    logic                  sv_reg;
    logic                  press_nz_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg, sx_reg, sy_reg;

    logic                  started_reg;
    logic                  last_nz_reg;
    logic                  pass_reg;
    logic                  iir_reg;

    logic                  result_valid_reg;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;

    logic [WEIGHT_W-1:0]   weight_new;
    logic [WEIGHT_W-1:0]   weight_old;
    logic [WEIGHT_W-1:0]   weight_blend;
    logic                  too_big_x, too_big_y;
    logic [COORD_BITS-1:0] coord_x, coord_y;
    logic                  clear_eff, pass_now, started_eff;
    logic                  slot_free;
    lane_ctrl_t            lane_ctrl;

    // Weight clamps: new-delta weight to 3..256, blend weight to at most 256.
    always_comb
    begin
        priority if (smoothing_weight_reg < WEIGHT_W'(WEIGHT_MIN))
        begin
            weight_new = WEIGHT_W'(WEIGHT_MIN);
        end
        else if (smoothing_weight_reg > WEIGHT_W'(WEIGHT_ONE))
        begin
            weight_new = WEIGHT_W'(WEIGHT_ONE);
        end
        else
        begin
            weight_new = smoothing_weight_reg;
        end
    end

    assign weight_old   = WEIGHT_W'(WEIGHT_ONE) - weight_new;
    assign weight_blend = (blend_weight_reg > WEIGHT_W'(WEIGHT_ONE)) ?
                          WEIGHT_W'(WEIGHT_ONE) : blend_weight_reg;

    // Frame decisions, valid while the sequencer is in its check step.
    assign clear_eff   = enable_reg && (!pv_reg || (last_nz_reg && !press_nz_reg));
    assign pass_now    = !enable_reg || !pv_reg || !sv_reg || too_big_x || too_big_y;
    assign started_eff = started_reg && !clear_eff;

    always_comb
    begin
        lane_ctrl            = '0;
        lane_ctrl.clear      = (state_reg == ST_CHECK) && clear_eff;
        lane_ctrl.seed       = (state_reg == ST_CHECK) && !pass_now && !started_eff;
        lane_ctrl.smooth_mul = (state_reg == ST_CHECK) && !pass_now && started_eff;
        lane_ctrl.smooth_upd = (state_reg == ST_SMOOTH) && iir_reg;
        lane_ctrl.blend_mul  = (state_reg == ST_BLEND);
    end

    scdb_lane u_lane_x (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lane_ctrl),
        .base         (px_reg),
        .other        (sx_reg),
        .max_delta    (max_delta_reg),
        .weight_new   (weight_new),
        .weight_old   (weight_old),
        .weight_blend (weight_blend),
        .too_big      (too_big_x),
        .coord        (coord_x)
    );

    scdb_lane u_lane_y (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lane_ctrl),
        .base         (py_reg),
        .other        (sy_reg),
        .max_delta    (max_delta_reg),
        .weight_new   (weight_new),
        .weight_old   (weight_old),
        .weight_blend (weight_blend),
        .too_big      (too_big_y),
        .coord        (coord_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg           <= ENABLE_RESET;
            max_delta_reg        <= MAX_DELTA_RESET;
            smoothing_weight_reg <= SMOOTH_RESET;
            blend_weight_reg     <= BLEND_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ENABLE:           enable_reg           <= wr_data[0];
                REG_MAX_DELTA:        max_delta_reg        <= wr_data;
                REG_SMOOTHING_WEIGHT: smoothing_weight_reg <= wr_data[WEIGHT_W-1:0];
                REG_BLEND_WEIGHT:     blend_weight_reg     <= wr_data[WEIGHT_W-1:0];
            endcase
        end
    end

    assign frame.ready = (state_reg == ST_IDLE);
    assign slot_free   = !result_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            started_reg      <= 1'b0;
            last_nz_reg      <= 1'b0;
            pass_reg         <= 1'b1;
            iir_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // In the last step the result register is handled by the load below.
            if (result_valid_reg && result.ready && (state_reg != ST_DONE))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (frame.valid)
                    begin
                        pv_reg       <= frame.primary_valid;
                        px_reg       <= frame.primary_x;
                        py_reg       <= frame.primary_y;
                        sv_reg       <= frame.secondary_valid;
                        sx_reg       <= frame.secondary_x;
                        sy_reg       <= frame.secondary_y;
                        press_nz_reg <= (frame.pressure != '0);
                        state_reg    <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    pass_reg <= pass_now;
                    iir_reg  <= !pass_now && started_eff;
                    if (!pass_now)
                    begin
                        started_reg <= 1'b1;
                    end
                    else if (clear_eff)
                    begin
                        started_reg <= 1'b0;
                    end
                    if (enable_reg && pv_reg)
                    begin
                        last_nz_reg <= press_nz_reg;
                    end
                    state_reg <= ST_SMOOTH;
                end
                ST_SMOOTH:
                begin
                    state_reg <= ST_BLEND;
                end
                ST_BLEND:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        result_valid_reg <= 1'b1;
                        out_valid_reg    <= pv_reg;
                        out_x_reg        <= pass_reg ? px_reg : coord_x;
                        out_y_reg        <= pass_reg ? py_reg : coord_y;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid     = result_valid_reg;
    assign result.out_valid = out_valid_reg;
    assign result.out_x     = out_x_reg;
    assign result.out_y     = out_y_reg;

    // A result appears only as the sequencer leaves its last step.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

    // An enabled frame with an invalid primary leaves smoothing stopped.
    a_invalid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && enable_reg && !pv_reg) |=> !started_reg)
        else $error("smoothing still running after an invalid primary");

    // A disabled block never touches the smoothing state.
    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !enable_reg) |=>
            ($stable(started_reg) && $stable(last_nz_reg)))
        else $error("smoothing state changed while disabled");

endmodule

@@ dv/stylus_coordinate_delta_blender_tb.sv @@
// Self-checking testbench for the stylus coordinate delta blender: a queue-fed frame
// driver, a result monitor and a cycle-free predictor of the smoothing and blending.
// Depends on scdb_pkg, scdb_if and the stylus_coordinate_delta_blender top level.
module stylus_coordinate_delta_blender_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scdb_pkg::*;

    typedef struct packed {
        logic        primary_valid;
        logic [15:0] primary_x;
        logic [15:0] primary_y;
        logic        secondary_valid;
        logic [15:0] secondary_x;
        logic [15:0] secondary_y;
        logic [15:0] pressure;
    } frame_t;

    typedef struct packed {
        logic        out_valid;
        logic [15:0] out_x;
        logic [15:0] out_y;
    } coord_t;

    localparam int PHASES     = 9;
    localparam int PHASE_LEN  = 150;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 4;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                wr_en;
    reg_index_t          wr_index;
    logic [CFG_W-1:0]    wr_data;

    scdb_frame_if  frame_ch ();
    scdb_result_if result_ch ();

    stylus_coordinate_delta_blender dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .frame    (frame_ch),
        .result   (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copy and smoothing state of the predictor.
    bit                       cfg_enable     = ENABLE_RESET;
    bit [15:0]                cfg_max_delta  = MAX_DELTA_RESET;
    bit [8:0]                 cfg_smooth_w   = SMOOTH_RESET;
    bit [8:0]                 cfg_blend_w    = BLEND_RESET;
    bit                       filt_started   = 1'b0;
    logic signed [SMOOTH_W-1:0] avg_dx       = '0;
    logic signed [SMOOTH_W-1:0] avg_dy       = '0;
    bit                       pen_down       = 1'b0;

    frame_t pending_frames[$];
    coord_t expected_coords[$];
    frame_t offered;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_requests     = 0;
    int hold_served       = 0;
    int hold_left         = 0;
    int mismatches        = 0;

    function automatic longint div_round_away(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic void clear_filter();
        filt_started = 1'b0;
        avg_dx = '0;
        avg_dy = '0;
    endfunction

    function automatic longint iir_step(longint s, longint raw, longint a);
        return div_round_away(s * (WEIGHT_ONE - a) + (raw <<< FRAC_BITS) * a, WEIGHT_BITS);
    endfunction

    function automatic logic [15:0] apply_offset(logic [15:0] base, longint s, longint b);
        longint sum;
        sum = longint'(base) + div_round_away(s * b, WEIGHT_BITS + FRAC_BITS);
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 <<< COORD_BITS) - 1)
            sum = (64'sd1 <<< COORD_BITS) - 1;
        return sum[15:0];
    endfunction

    // Updates the smoothing state for one frame and returns the coordinate it yields.
    function automatic coord_t blend_frame(frame_t f);
        coord_t r;
        longint dx;
        longint dy;
        longint a;
        longint b;
        r.out_valid = f.primary_valid;
        r.out_x = f.primary_x;
        r.out_y = f.primary_y;
        if (!cfg_enable)
            return r;
        if (!f.primary_valid)
        begin
            clear_filter();
            return r;
        end
        if (pen_down && f.pressure == 0)
            clear_filter();
        pen_down = (f.pressure != 0);
        if (!f.secondary_valid)
            return r;
        dx = longint'(f.secondary_x) - longint'(f.primary_x);
        dy = longint'(f.secondary_y) - longint'(f.primary_y);
        if ((dx < 0 ? -dx : dx) > longint'(cfg_max_delta)
            || (dy < 0 ? -dy : dy) > longint'(cfg_max_delta))
            return r;
        a = longint'(cfg_smooth_w);
        b = longint'(cfg_blend_w);
        if (a < WEIGHT_MIN)
            a = WEIGHT_MIN;
        if (a > WEIGHT_ONE)
            a = WEIGHT_ONE;
        if (b > WEIGHT_ONE)
            b = WEIGHT_ONE;
        if (!filt_started)
        begin
            avg_dx = SMOOTH_W'(dx <<< FRAC_BITS);
            avg_dy = SMOOTH_W'(dy <<< FRAC_BITS);
            filt_started = 1'b1;
        end
        else
        begin
            avg_dx = SMOOTH_W'(iir_step(longint'(avg_dx), dx, a));
            avg_dy = SMOOTH_W'(iir_step(longint'(avg_dy), dy, a));
        end
        r.out_x = apply_offset(f.primary_x, longint'(avg_dx), b);
        r.out_y = apply_offset(f.primary_y, longint'(avg_dy), b);
        return r;
    endfunction

    // Frame driver: a new item goes out once the previous one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.valid <= 1'b0;
            frame_ch.primary_valid <= 1'b0;
            frame_ch.primary_x <= '0;
            frame_ch.primary_y <= '0;
            frame_ch.secondary_valid <= 1'b0;
            frame_ch.secondary_x <= '0;
            frame_ch.secondary_y <= '0;
            frame_ch.pressure <= '0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
                expected_coords.push_back(blend_frame(offered));
            if (!frame_ch.valid || frame_ch.ready)
            begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    offered = pending_frames.pop_front();
                    frame_ch.valid <= 1'b1;
                    frame_ch.primary_valid <= offered.primary_valid;
                    frame_ch.primary_x <= offered.primary_x;
                    frame_ch.primary_y <= offered.primary_y;
                    frame_ch.secondary_valid <= offered.secondary_valid;
                    frame_ch.secondary_x <= offered.secondary_x;
                    frame_ch.secondary_y <= offered.secondary_y;
                    frame_ch.pressure <= offered.pressure;
                end
                else
                    frame_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure, including the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        coord_t want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_coords.size() == 0)
                begin
                    $error("unexpected result: out_x %0d out_y %0d",
                           result_ch.out_x, result_ch.out_y);
                    mismatches++;
                end
                else
                begin
                    want = expected_coords.pop_front();
                    if (result_ch.out_valid !== want.out_valid)
                    begin
                        $error("out_valid: expected %0d, got %0d",
                               want.out_valid, result_ch.out_valid);
                        mismatches++;
                    end
                    if (result_ch.out_x !== want.out_x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.out_x, result_ch.out_x);
                        mismatches++;
                    end
                    if (result_ch.out_y !== want.out_y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.out_y, result_ch.out_y);
                        mismatches++;
                    end
                end
            end
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic int clip_coord(int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function automatic int pick_base();
        case ($urandom_range(3))
            0: return int'($urandom_range(200));
            1: return 65535 - int'($urandom_range(200));
            default: return int'($urandom_range(65535));
        endcase
    endfunction

    task automatic push_frame(int pv, int px, int py, int sv, int sx, int sy, int pr);
        frame_t f;
        f.primary_valid = pv[0];
        f.primary_x = 16'(px);
        f.primary_y = 16'(py);
        f.secondary_valid = sv[0];
        f.secondary_x = 16'(sx);
        f.secondary_y = 16'(sy);
        f.pressure = 16'(pr);
        pending_frames.push_back(f);
    endtask

    // One pen stroke: a drifting primary with a secondary at a steady offset, plus
    // occasional dropouts, out-of-limit offsets and pressure lifts.
    task automatic push_stroke(int len, int lim);
        int px;
        int py;
        int bx;
        int by;
        int dx;
        int dy;
        int pr;
        px = pick_base();
        py = pick_base();
        bx = int'($urandom_range(2 * lim)) - lim;
        by = int'($urandom_range(2 * lim)) - lim;
        for (int i = 0; i < len; i++)
        begin
            px = clip_coord(px + int'($urandom_range(40)) - 20);
            py = clip_coord(py + int'($urandom_range(40)) - 20);
            dx = bx + int'($urandom_range(8)) - 4;
            dy = by + int'($urandom_range(8)) - 4;
            dx = (dx > lim) ? lim : ((dx < -lim) ? -lim : dx);
            dy = (dy > lim) ? lim : ((dy < -lim) ? -lim : dy);
            if ($urandom_range(99) < 5)
                dx = (px > 32767) ? -(lim + 1) : lim + 1;
            if ($urandom_range(99) < 5)
                dy = (py > 32767) ? -(lim + 1) : lim + 1;
            pr = ($urandom_range(99) < 3) ? 0 : int'($urandom_range(65535, 1));
            if (i == len - 1 && $urandom_range(1) == 1)
                pr = 0;
            push_frame(int'($urandom_range(99) >= 4), px, py,
                       int'($urandom_range(99) >= 6),
                       clip_coord(px + dx), clip_coord(py + dy), pr);
        end
    endtask

    task automatic wait_drained();
        while (pending_frames.size() != 0 || frame_ch.valid || expected_coords.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, int unsigned val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= CFG_W'(val);
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_ENABLE:           cfg_enable = val[0];
            REG_MAX_DELTA:        cfg_max_delta = val[15:0];
            REG_SMOOTHING_WEIGHT: cfg_smooth_w = val[8:0];
            REG_BLEND_WEIGHT:     cfg_blend_w = val[8:0];
            default: ;
        endcase
    endtask

    initial
    begin
        #5_000_000;
        $display("stylus_coordinate_delta_blender regression: fail");
        $finish;
    end

    initial
    begin
        // enable, max_delta, smoothing_weight, blend_weight; the last row's last three are redrawn.
        int unsigned settings[PHASES][4] = '{
            '{1, 64, 64, 128},
            '{1, 65535, 256, 256},
            '{1, 0, 3, 128},
            '{0, 100, 64, 128},
            '{1, 200, 0, 511},
            '{1, 1000, 511, 0},
            '{1, 30, 17, 300},
            '{1, 4096, 128, 200},
            '{1, 0, 0, 0}
        };
        int queued;
        int len;

        wr_en = 1'b0;
        wr_index = REG_ENABLE;
        wr_data = '0;
        frame_ch.valid = 1'b0;
        frame_ch.primary_valid = 1'b0;
        frame_ch.primary_x = '0;
        frame_ch.primary_y = '0;
        frame_ch.secondary_valid = 1'b0;
        frame_ch.secondary_x = '0;
        frame_ch.secondary_y = '0;
        frame_ch.pressure = '0;
        result_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset settings.
        sender_idle_pct = 18;
        receiver_idle_pct = 50;
        push_frame(0, 65535, 0, 1, 65535, 0, 65535);
        push_frame(1, 1000, 2000, 0, 0, 0, 100);
        push_frame(1, 1000, 2000, 1, 1064, 1936, 100);
        push_frame(1, 1000, 2000, 1, 1010, 1990, 100);
        push_frame(1, 1000, 2000, 1, 1065, 2000, 100);
        push_frame(1, 1000, 2000, 1, 1000, 1935, 100);
        push_frame(1, 1000, 2000, 1, 1003, 1997, 0);
        push_frame(1, 1000, 2000, 1, 1005, 1995, 0);
        push_frame(1, 65500, 65500, 1, 65535, 65535, 65535);
        push_frame(1, 65535, 65535, 1, 65535, 65535, 65535);
        push_frame(1, 65535, 65535, 1, 65535, 65535, 65535);
        push_frame(0, 0, 0, 0, 0, 0, 0);
        push_frame(1, 40, 40, 1, 0, 0, 1);
        push_frame(1, 0, 0, 1, 0, 0, 1);
        push_frame(1, 0, 0, 1, 0, 0, 1);
        push_frame(1, 0, 65535, 1, 64, 65471, 65535);
        push_frame(1, 65535, 0, 1, 0, 65535, 32768);
        push_frame(1, 12345, 54321, 1, 12346, 54320, 1);
        push_frame(1, 12345, 54321, 1, 12345, 54321, 21845);
        push_frame(1, 43690, 21845, 1, 43689, 21846, 43690);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                settings[p][1] = $urandom_range(65535);
                settings[p][2] = $urandom_range(511);
                settings[p][3] = $urandom_range(511);
            end
            write_reg(REG_ENABLE, settings[p][0]);
            write_reg(REG_MAX_DELTA, settings[p][1]);
            write_reg(REG_SMOOTHING_WEIGHT, settings[p][2]);
            write_reg(REG_BLEND_WEIGHT, settings[p][3]);

            // Idling moves from a slow receiver to a slow sender, then none at all.
            sender_idle_pct = (p < 3) ? 18 : ((p < 6) ? 50 : 0);
            receiver_idle_pct = (p < 3) ? 50 : ((p < 6) ? 18 : 0);
            // A long receiver hold-off while the sender keeps offering items.
            if (p == 1 || p == 4)
                hold_requests++;

            queued = 0;
            while (queued < PHASE_LEN)
            begin
                len = $urandom_range(30, 4);
                if (len > PHASE_LEN - queued)
                    len = PHASE_LEN - queued;
                push_stroke(len, int'(cfg_max_delta));
                queued += len;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("stylus_coordinate_delta_blender regression: pass");
        else
            $display("stylus_coordinate_delta_blender regression: fail");
        $finish;
    end

endmodule
